// ===== rtl/vdss_pkg.sv =====
// Package with the types, codes and reset constants of the drive state sequencer.
`timescale 1ns / 1ps

package vdss_pkg;

  // Widths of the beat fields.
  localparam int unsigned LevelW   = 12;
  localparam int unsigned BuzzW    = 16;
  localparam int unsigned MsW      = 32;
  localparam int unsigned StateW   = 3;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  // Register values after reset.
  localparam logic [LevelW-1:0] BrakeOnReset  = 12'd200;
  localparam logic [LevelW-1:0] BrakeOffReset = 12'd100;
  localparam logic [BuzzW-1:0]  MinBuzzReset  = 16'd2000;

  // Drive states; code 7 is unused and is treated as a fault.
  typedef enum logic [StateW-1:0] {
    ST_INIT        = 3'd0,
    ST_IDLE        = 3'd1,
    ST_PRECHARGING = 3'd2,
    ST_ENERGIZED   = 3'd3,
    ST_BUZZING     = 3'd4,
    ST_READY2DRIVE = 3'd5,
    ST_FATAL       = 3'd6
  } state_t;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_BRAKE_ON  = 2'd0,
    CFG_BRAKE_OFF = 2'd1,
    CFG_MIN_BUZZ  = 2'd2
  } cfg_idx_t;

endpackage

// ===== rtl/vehicle_drive_state_sequencer_core.sv =====
// Top level of the vehicle drive state sequencer: input register, step logic, result register.
`timescale 1ns / 1ps

// One input beat is one control tick. The tick is held in an input register, the next
// state, brake light and buzzer are worked out in one short pass of logic, and the
// result beat is held in an output register. With the result side ready a tick is
// taken every clock cycle; its result passes the input and output registers; a
// stalled result holds the input register, which then holds in_tready low. The
// sequence runs INIT, IDLE, PRECHARGING, ENERGIZED, BUZZING, READY2DRIVE, back to
// IDLE; an open shutdown circuit forces FATAL, which returns to IDLE. The three
// configuration registers are written by index through cfg_we and should only be
// changed while no tick is in flight.
module vehicle_drive_state_sequencer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input beat
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] sdc_closed, [1] precharge_done, [2] start_pressed, [3] start_stale,
  // [15:4] brake_level, [47:16] now_ms
  input  logic [vdss_pkg::InDataW-1:0]       in_tdata,
  // Result beat
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] state_now, [5:3] state_after, [6] brake_light_on, [7] buzzer_on,
  // [8] sdc_trip, [15:9] zero
  output logic [vdss_pkg::OutDataW-1:0]      out_tdata,
  // Configuration writes
  input  logic                               cfg_we,
  input  logic [vdss_pkg::CfgAddrW-1:0]      cfg_addr,
  input  logic [vdss_pkg::CfgDataW-1:0]      cfg_wdata
);

  // Configuration registers.
  logic [vdss_pkg::LevelW-1:0] brake_on_r;
  logic [vdss_pkg::LevelW-1:0] brake_off_r;
  logic [vdss_pkg::BuzzW-1:0]  min_buzz_r;

  // Sequencer state.
  vdss_pkg::state_t            pending_r;
  vdss_pkg::state_t            pending_nxt;
  logic                        lamp_r;
  logic                        lamp_nxt;
  logic                        buzzer_r;
  logic                        buzzer_nxt;
  logic [vdss_pkg::MsW-1:0]    buzz_start_r;
  logic [vdss_pkg::MsW-1:0]    buzz_start_nxt;
  logic                        trip;

  // Pipeline registers.
  logic                         in_v_r;
  logic [vdss_pkg::InDataW-1:0] in_data_r;
  logic                         out_v_r;
  logic [vdss_pkg::OutDataW-1:0] out_data_r;
  logic [vdss_pkg::OutDataW-1:0] out_data_nxt;
  logic                         step_go;

  // Fields of the held tick.
  logic                        sdc_closed;
  logic                        precharge_done;
  logic                        start_ok;
  logic [vdss_pkg::LevelW-1:0] brake_level;
  logic [vdss_pkg::MsW-1:0]    now_ms;
  logic [vdss_pkg::MsW-1:0]    elapsed;
  vdss_pkg::state_t            cur_state;

  assign sdc_closed     = in_data_r[0];
  assign precharge_done = in_data_r[1];
  assign start_ok       = in_data_r[2] & ~in_data_r[3];
  assign brake_level    = in_data_r[15:4];
  assign now_ms         = in_data_r[47:16];
  assign cur_state      = pending_r;
  assign elapsed        = now_ms - buzz_start_r;

  // Handshake: the step runs when a tick is held and the result register is free.
  assign step_go    = in_v_r & (~out_v_r | out_tready);
  assign in_tready  = ~in_v_r | step_go;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brake_on_r  <= vdss_pkg::BrakeOnReset;
      brake_off_r <= vdss_pkg::BrakeOffReset;
      min_buzz_r  <= vdss_pkg::MinBuzzReset;
    end else if (cfg_we) begin
      unique case (vdss_pkg::cfg_idx_t'(cfg_addr))
        vdss_pkg::CFG_BRAKE_ON:  brake_on_r  <= cfg_wdata[vdss_pkg::LevelW-1:0];
        vdss_pkg::CFG_BRAKE_OFF: brake_off_r <= cfg_wdata[vdss_pkg::LevelW-1:0];
        vdss_pkg::CFG_MIN_BUZZ:  min_buzz_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One control tick: shutdown check, brake light hysteresis and state advance.
  always_comb begin
    pending_nxt    = cur_state;
    lamp_nxt       = lamp_r;
    buzzer_nxt     = buzzer_r;
    buzz_start_nxt = buzz_start_r;
    trip           = 1'b0;
    if (!sdc_closed) begin
      pending_nxt = vdss_pkg::ST_FATAL;
      trip        = 1'b1;
    end else begin
      // The on test wins when the thresholds are crossed over.
      if (brake_level > brake_on_r) begin
        lamp_nxt = 1'b1;
      end else if (brake_level < brake_off_r) begin
        lamp_nxt = 1'b0;
      end
      unique case (cur_state)
        vdss_pkg::ST_INIT:        pending_nxt = vdss_pkg::ST_IDLE;
        vdss_pkg::ST_IDLE:        pending_nxt = vdss_pkg::ST_PRECHARGING;
        vdss_pkg::ST_PRECHARGING: begin
          if (precharge_done) pending_nxt = vdss_pkg::ST_ENERGIZED;
        end
        vdss_pkg::ST_ENERGIZED: begin
          if (start_ok) begin
            buzz_start_nxt = now_ms;
            pending_nxt    = vdss_pkg::ST_BUZZING;
          end
        end
        vdss_pkg::ST_BUZZING: begin
          buzzer_nxt = 1'b1;
          if (elapsed >= {{(vdss_pkg::MsW-vdss_pkg::BuzzW){1'b0}}, min_buzz_r}) begin
            buzzer_nxt  = 1'b0;
            pending_nxt = vdss_pkg::ST_READY2DRIVE;
          end
        end
        vdss_pkg::ST_READY2DRIVE: begin
          if (start_ok) pending_nxt = vdss_pkg::ST_IDLE;
        end
        vdss_pkg::ST_FATAL:       pending_nxt = vdss_pkg::ST_IDLE;
        default:                  pending_nxt = vdss_pkg::ST_FATAL;
      endcase
    end
    out_data_nxt = {7'd0, trip, buzzer_nxt, lamp_nxt, pending_nxt, cur_state};
  end

  // Sequencer state moves on each time a step runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= vdss_pkg::ST_INIT;
      lamp_r       <= 1'b0;
      buzzer_r     <= 1'b0;
      buzz_start_r <= '0;
    end else if (step_go) begin
      pending_r    <= pending_nxt;
      lamp_r       <= lamp_nxt;
      buzzer_r     <= buzzer_nxt;
      buzz_start_r <= buzz_start_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_go) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  // A tripped step always reports FATAL as the next state.
  a_trip_fatal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[5:3] == vdss_pkg::ST_FATAL)
    else $error("tripped step without FATAL next state");

  // The latched next state matches the state_after of the result just produced.
  a_state_kept: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |=> pending_r == out_data_r[5:3])
    else $error("latched state differs from reported next state");

  // The buzzer only switches on while buzzing.
  a_buzz_on: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && !buzzer_r && buzzer_nxt |-> cur_state == vdss_pkg::ST_BUZZING)
    else $error("buzzer switched on outside BUZZING");

  // A result waiting on a stalled output is not overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |-> !step_go)
    else $error("result overwritten while stalled");
`endif

endmodule
